// ----- src/mbpr_pkg.sv -----
`timescale 1ns / 1ps
package mbpr_pkg;

	typedef enum logic [2:0] {
		ACT_LOAD_COEF = 3'd0,
		ACT_LOAD_NODE = 3'd1,
		ACT_SET_WEIGHT = 3'd2,
		ACT_RECON = 3'd3,
		ACT_CLEAR = 3'd4,
		ACT_PROJECT = 3'd5,
		ACT_READ = 3'd6,
		ACT_BAD = 3'd7
	} action_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_RANGE = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		FSM_IDLE,
		FSM_SCAN,
		FSM_MAC,
		FSM_DRAIN,
		FSM_OUT
	} fsm_t;

	localparam int SUM_W = 52;
	localparam int COORD_W = 24;
	localparam int COEF_W = 16;
	localparam int ID_W = 20;
	localparam int CFG_IDX_MODES = 0;
	localparam int CFG_IDX_NODES = 1;

	localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
	localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

	// saturate a 56-bit signed value to 52 bits
	function automatic logic signed [SUM_W-1:0] sat52(input logic signed [55:0] v);
		logic signed [55:0] hi;
		logic signed [55:0] lo;
		hi = 56'(SUM_MAX);
		lo = {{4{1'b1}}, SUM_MIN};
		if (v > hi) return SUM_MAX;
		else if (v < lo) return SUM_MIN;
		else return v[SUM_W-1:0];
	endfunction

endpackage

// ----- src/mbpr_lane.sv -----
`timescale 1ns / 1ps
// One node-table lane: holds every LANES-th slot, scans them one per cycle
// and reports the last matching slot it owns. The table read is registered,
// so a compare lands in the cycle after its slot is presented.
module mbpr_lane #(
	parameter int SLOTS = 64,
	parameter int SLOT_W = 6
) (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  logic [SLOT_W-1:0] wr_slot,
	input  logic [mbpr_pkg::ID_W-1:0] wr_id,
	input  logic scan_start,
	input  logic scan_en,
	input  logic [SLOT_W-1:0] scan_slot,
	input  logic scan_live,
	input  logic [mbpr_pkg::ID_W-1:0] key,
	output logic found,
	output logic [SLOT_W-1:0] hit_slot
);
	logic [mbpr_pkg::ID_W-1:0] ids_q [SLOTS];
	logic [SLOTS-1:0] valid_q;
	logic found_q;
	logic [SLOT_W-1:0] hit_q;
	logic [mbpr_pkg::ID_W-1:0] id_s1;
	logic cmp_s1;
	logic [SLOT_W-1:0] slot_s1;

	always_ff @(posedge clk) begin
		if (wr_en) ids_q[wr_slot] <= wr_id;
		id_s1 <= ids_q[scan_slot];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			found_q <= 1'b0;
			hit_q <= '0;
			cmp_s1 <= 1'b0;
			slot_s1 <= '0;
		end else begin
			if (wr_en) valid_q[wr_slot] <= 1'b1;
			cmp_s1 <= scan_en && scan_live && valid_q[scan_slot];
			slot_s1 <= scan_slot;
			if (scan_start) found_q <= 1'b0;
			else if (cmp_s1 && id_s1 == key) begin
				found_q <= 1'b1;
				hit_q <= slot_s1;
			end
		end
	end

	assign found = found_q;
	assign hit_slot = hit_q;
endmodule

// ----- src/mbpr_mac.sv -----
`timescale 1ns / 1ps
// Multiply-accumulate: one 16x24 product per cycle, registered, then
// accumulated into a 56-bit sum.
module mbpr_mac (
	input  logic clk,
	input  logic arst_n,
	input  logic clr,
	input  logic en,
	input  logic signed [mbpr_pkg::COEF_W-1:0] a,
	input  logic signed [mbpr_pkg::COORD_W-1:0] b,
	output logic signed [55:0] acc,
	output logic busy
);
	logic signed [39:0] prod_s1;
	logic vld_s1;
	logic signed [55:0] acc_q;

	always_ff @(posedge clk) begin
		prod_s1 <= a * b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			acc_q <= '0;
		end else begin
			vld_s1 <= en;
			if (clr) acc_q <= '0;
			else if (vld_s1) acc_q <= acc_q + 56'(prod_s1);
		end
	end

	assign acc = acc_q;
	assign busy = vld_s1;
endmodule

// ----- src/modal_basis_project_reconstruct_unit.sv -----
`timescale 1ns / 1ps
// Modal basis projection / reconstruction unit.
// Input channel: in_valid/in_stall with one field port each; one beat is one
// action. Output channel: out_valid/out_stall carrying status and
// result_value, exactly one beat per input beat, in order.
// Config: cfg_we/cfg_index/cfg_data, to be written only while idle (not enforced by the block).
// Timing: one item at a time. Loads, weight, clear, read and range errors
// go from the accepting edge straight to the output register. Reconstruct
// walks the modes through one multiplier. Projection scans the node table
// in LANES parallel lanes (table read registered), then does 3 products per
// active mode through the same multiplier; an unknown id answers NOT_FOUND
// and issues no products. The next beat is taken only once the result beat
// has been taken and the unit is back in idle.
// The basis memory has one read port. Reset clears the node valid bits,
// the accumulators and the counts; basis and weights are undefined until
// written. The result waits in an output register while out_stall is high;
// in_stall stays high until it is taken.
module modal_basis_project_reconstruct_unit #(
	parameter int MAX_MODES = 16,
	parameter int MAX_NODES = 256,
	parameter int LANES = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic cfg_index,
	input  logic [8:0] cfg_data,
	input  logic in_valid,
	output logic in_stall,
	input  logic [2:0] action,
	input  logic [3:0] mode_index,
	input  logic [9:0] coord_index,
	input  logic [7:0] node_slot,
	input  logic [19:0] node_id,
	input  logic signed [15:0] coefficient,
	input  logic signed [23:0] weight,
	input  logic signed [23:0] x_coord,
	input  logic signed [23:0] y_coord,
	input  logic signed [23:0] z_coord,
	output logic out_valid,
	input  logic out_stall,
	output logic [1:0] status,
	output logic signed [51:0] result_value
);
	localparam int MODE_W = (MAX_MODES > 1) ? $clog2(MAX_MODES) : 1;
	localparam int NODE_W = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
	localparam int ROW = 3 * MAX_NODES;
	localparam int COL_W = $clog2(ROW);
	localparam int DEPTH = MAX_MODES * ROW;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int LPER = (MAX_NODES + LANES - 1) / LANES;
	localparam int LSLOT_W = (LPER > 1) ? $clog2(LPER) : 1;
	localparam int MCNT_W = $clog2(MAX_MODES + 1);
	localparam int NCNT_W = $clog2(MAX_NODES + 1);

	logic [4:0] modes_cfg_q;
	logic [8:0] nodes_cfg_q;
	logic [MCNT_W-1:0] modes;
	logic [NCNT_W-1:0] nodes;
	logic [NCNT_W+1:0] coords;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modes_cfg_q <= 5'd16;
			nodes_cfg_q <= 9'd256;
		end else if (cfg_we) begin
			if (cfg_index == 1'(mbpr_pkg::CFG_IDX_MODES)) modes_cfg_q <= cfg_data[4:0];
			else nodes_cfg_q <= cfg_data;
		end
	end

	always_comb begin
		if (modes_cfg_q == '0) modes = MCNT_W'(1);
		else if (32'(modes_cfg_q) > MAX_MODES) modes = MCNT_W'(MAX_MODES);
		else modes = MCNT_W'(modes_cfg_q);
		if (nodes_cfg_q == '0) nodes = NCNT_W'(1);
		else if (32'(nodes_cfg_q) > MAX_NODES) nodes = NCNT_W'(MAX_NODES);
		else nodes = NCNT_W'(nodes_cfg_q);
		coords = (NCNT_W+2)'(nodes) * (NCNT_W+2)'(3);
	end

	// item registers
	mbpr_pkg::action_t act_q;
	logic [9:0] coord_q;
	logic [19:0] id_q;
	logic signed [23:0] px_q, py_q, pz_q;
	mbpr_pkg::fsm_t st_q, st_d;
	logic [1:0] st_res_q;
	logic signed [51:0] res_q;
	logic out_q;

	logic accept;
	assign accept = in_valid && !in_stall;
	assign in_stall = (st_q != mbpr_pkg::FSM_IDLE);

	// range checks on the incoming beat
	logic mode_ok, coord_ok, slot_ok;
	assign mode_ok = 32'(mode_index) < 32'(modes);
	assign coord_ok = 32'(coord_index) < 32'(coords);
	assign slot_ok = 32'(node_slot) < 32'(nodes);

	// memories
	logic signed [15:0] basis_mem [DEPTH];
	logic signed [23:0] wt_mem [MAX_MODES];
	logic signed [51:0] sums_q [MAX_MODES];
	logic [ADDR_W-1:0] rd_addr;
	logic signed [15:0] basis_rd;
	logic [MODE_W-1:0] wt_addr;
	logic signed [23:0] wt_rd;
	logic do_load_coef, do_set_w;

	assign do_load_coef = accept && action == 3'(mbpr_pkg::ACT_LOAD_COEF) && mode_ok
		&& coord_ok && 32'(mode_index) < MAX_MODES && 32'(coord_index) < ROW;
	assign do_set_w = accept && action == 3'(mbpr_pkg::ACT_SET_WEIGHT) && mode_ok
		&& 32'(mode_index) < MAX_MODES;

	always_ff @(posedge clk) begin
		if (do_load_coef)
			basis_mem[ADDR_W'(32'(mode_index) * ROW + 32'(coord_index))] <= coefficient;
		basis_rd <= basis_mem[rd_addr];
		if (do_set_w) wt_mem[MODE_W'(mode_index)] <= weight;
		wt_rd <= wt_mem[wt_addr];
	end

	// sequencing counters
	logic [MCNT_W-1:0] m_q;
	logic [1:0] ax_q;
	logic [LSLOT_W:0] sc_q;
	logic [NODE_W-1:0] loc;
	logic [COL_W-1:0] base_col;
	logic issue, issue_s1, issue_s2;
	logic [MCNT_W-1:0] m_s1, m_s2;
	logic last_ax_s1, last_ax_s2;
	logic [1:0] ax_s1;

	// lanes
	logic [LANES-1:0] l_found;
	logic [LSLOT_W-1:0] l_hit [LANES];
	logic any_found;

	for (genvar g = 0; g < LANES; g++) begin : g_lane
		logic wr;
		logic live;
		assign wr = accept && action == 3'(mbpr_pkg::ACT_LOAD_NODE) && slot_ok
			&& 32'(node_slot) % LANES == g && 32'(node_slot) < MAX_NODES;
		assign live = (32'(sc_q) * LANES + g) < 32'(nodes);
		mbpr_lane #(.SLOTS(LPER), .SLOT_W(LSLOT_W)) u_lane (
			.clk(clk), .arst_n(arst_n),
			.wr_en(wr), .wr_slot(LSLOT_W'(32'(node_slot) / LANES)), .wr_id(node_id),
			.scan_start(accept), .scan_en(st_q == mbpr_pkg::FSM_SCAN),
			.scan_slot(sc_q[LSLOT_W-1:0]), .scan_live(live), .key(id_q),
			.found(l_found[g]), .hit_slot(l_hit[g])
		);
	end

	// merge: highest global slot wins (last match)
	always_comb begin
		any_found = |l_found;
		loc = '0;
		for (int g = 0; g < LANES; g++) begin
			if (l_found[g] && (32'(l_hit[g]) * LANES + g) >= 32'(loc))
				loc = NODE_W'(32'(l_hit[g]) * LANES + g);
		end
	end
	assign base_col = COL_W'(32'(loc) * 3);

	// multiplier operand selection; basis_rd and wt_rd are registered and line up with issue_s1
	logic signed [23:0] mul_b;
	logic mac_clr;
	logic signed [55:0] mac_acc;
	logic mac_busy;
	always_comb begin
		if (act_q == mbpr_pkg::ACT_RECON) mul_b = wt_rd;
		else if (ax_s1 == 2'd0) mul_b = px_q;
		else if (ax_s1 == 2'd1) mul_b = py_q;
		else mul_b = pz_q;
	end

	mbpr_mac u_mac (
		.clk(clk), .arst_n(arst_n), .clr(mac_clr), .en(issue_s1),
		.a(basis_rd), .b(mul_b), .acc(mac_acc), .busy(mac_busy)
	);

	always_comb begin
		issue = (st_q == mbpr_pkg::FSM_MAC);
		wt_addr = MODE_W'(m_q);
		if (act_q == mbpr_pkg::ACT_RECON)
			rd_addr = ADDR_W'(32'(m_q) * ROW + 32'(coord_q));
		else
			rd_addr = ADDR_W'(32'(m_q) * ROW + 32'(base_col) + 32'(ax_q));
	end

	// next state
	always_comb begin
		st_d = st_q;
		case (st_q)
			mbpr_pkg::FSM_IDLE: begin
				if (accept) begin
					if (action == 3'(mbpr_pkg::ACT_RECON) && coord_ok) st_d = mbpr_pkg::FSM_MAC;
					else if (action == 3'(mbpr_pkg::ACT_PROJECT)) st_d = mbpr_pkg::FSM_SCAN;
					else st_d = mbpr_pkg::FSM_OUT;
				end
			end
			mbpr_pkg::FSM_SCAN: begin
				// the extra scan step at sc_q == LPER lets the last registered compare land
				if (32'(sc_q) == LPER) st_d = mbpr_pkg::FSM_MAC;
			end
			mbpr_pkg::FSM_MAC: begin
				if (act_q == mbpr_pkg::ACT_PROJECT && !any_found) st_d = mbpr_pkg::FSM_OUT;
				else if (m_q == modes - MCNT_W'(1)
						&& (act_q == mbpr_pkg::ACT_RECON || ax_q == 2'd2))
					st_d = mbpr_pkg::FSM_DRAIN;
			end
			mbpr_pkg::FSM_DRAIN: begin
				if (!issue_s1 && !issue_s2 && !mac_busy) st_d = mbpr_pkg::FSM_OUT;
			end
			mbpr_pkg::FSM_OUT: begin
				if (!out_q) st_d = mbpr_pkg::FSM_IDLE;
			end
			default: st_d = mbpr_pkg::FSM_IDLE;
		endcase
	end

	assign mac_clr = (st_q == mbpr_pkg::FSM_IDLE);

	always_ff @(posedge clk) begin
		if (accept) begin
			act_q <= mbpr_pkg::action_t'(action);
			coord_q <= coord_index;
			id_q <= node_id;
			px_q <= x_coord;
			py_q <= y_coord;
			pz_q <= z_coord;
		end
	end

	// projection accumulate per mode: after the third product lands, the MAC
	// sum holds prior partial sums, so track per-mode add separately
	logic signed [55:0] mode_base_q;
	logic last_s3;
	logic [MCNT_W-1:0] m_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= mbpr_pkg::FSM_IDLE;
			m_q <= '0;
			ax_q <= '0;
			sc_q <= '0;
			issue_s1 <= 1'b0;
			issue_s2 <= 1'b0;
			m_s1 <= '0;
			m_s2 <= '0;
			ax_s1 <= '0;
			last_ax_s1 <= 1'b0;
			last_ax_s2 <= 1'b0;
			last_s3 <= 1'b0;
			m_s3 <= '0;
			mode_base_q <= '0;
			out_q <= 1'b0;
			st_res_q <= 2'(mbpr_pkg::ST_OK);
			res_q <= '0;
			for (int i = 0; i < MAX_MODES; i++) sums_q[i] <= '0;
		end else begin
			st_q <= st_d;
			issue_s1 <= issue && !(act_q == mbpr_pkg::ACT_PROJECT && !any_found);
			issue_s2 <= issue_s1;
			m_s1 <= m_q;
			m_s2 <= m_s1;
			ax_s1 <= ax_q;
			last_ax_s1 <= (ax_q == 2'd2);
			last_ax_s2 <= last_ax_s1;
			last_s3 <= issue_s2 && last_ax_s2 && act_q == mbpr_pkg::ACT_PROJECT;
			m_s3 <= m_s2;
			if (accept) begin
				m_q <= '0;
				ax_q <= '0;
				sc_q <= '0;
				mode_base_q <= '0;
			end
			if (st_q == mbpr_pkg::FSM_SCAN) sc_q <= sc_q + 1'b1;
			if (issue) begin
				if (act_q == mbpr_pkg::ACT_RECON || ax_q == 2'd2) begin
					ax_q <= '0;
					m_q <= m_q + 1'b1;
				end else ax_q <= ax_q + 1'b1;
			end
			// mac_acc is running total; per-mode add = acc - base
			if (last_s3) begin
				sums_q[MODE_W'(m_s3)] <= mbpr_pkg::sat52(56'(sums_q[MODE_W'(m_s3)])
					+ (mac_acc - mode_base_q));
				mode_base_q <= mac_acc;
			end
			if (accept && action == 3'(mbpr_pkg::ACT_CLEAR))
				for (int i = 0; i < MAX_MODES; i++) sums_q[i] <= '0;
			// output register
			if (out_q && !out_stall) out_q <= 1'b0;
			if (accept) begin
				res_q <= '0;
				st_res_q <= 2'(mbpr_pkg::ST_OK);
				case (action)
					3'(mbpr_pkg::ACT_LOAD_COEF): if (!(mode_ok && coord_ok))
						st_res_q <= 2'(mbpr_pkg::ST_RANGE);
					3'(mbpr_pkg::ACT_LOAD_NODE): if (!slot_ok)
						st_res_q <= 2'(mbpr_pkg::ST_RANGE);
					3'(mbpr_pkg::ACT_SET_WEIGHT): if (!mode_ok)
						st_res_q <= 2'(mbpr_pkg::ST_RANGE);
					3'(mbpr_pkg::ACT_RECON): if (!coord_ok)
						st_res_q <= 2'(mbpr_pkg::ST_RANGE);
					3'(mbpr_pkg::ACT_CLEAR): ;
					3'(mbpr_pkg::ACT_PROJECT): ;
					3'(mbpr_pkg::ACT_READ): begin
						if (mode_ok) res_q <= sums_q[MODE_W'(mode_index)];
						else st_res_q <= 2'(mbpr_pkg::ST_RANGE);
					end
					default: st_res_q <= 2'(mbpr_pkg::ST_RANGE);
				endcase
			end
			if (st_q == mbpr_pkg::FSM_MAC && act_q == mbpr_pkg::ACT_PROJECT && !any_found)
				st_res_q <= 2'(mbpr_pkg::ST_NOT_FOUND);
			if (st_q == mbpr_pkg::FSM_DRAIN && st_d == mbpr_pkg::FSM_OUT
					&& act_q == mbpr_pkg::ACT_RECON)
				res_q <= mbpr_pkg::sat52(mac_acc);
			if (st_q != mbpr_pkg::FSM_OUT && st_d == mbpr_pkg::FSM_OUT) out_q <= 1'b1;
		end
	end

	assign out_valid = out_q;
	assign status = st_res_q;
	assign result_value = res_q;

	// the item path is busy whenever a result is pending
	a_busy_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall) else $error("result pending while idle");
	a_one_beat: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall) |=> !out_valid) else $error("result repeated");
	a_ok_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != 2'(mbpr_pkg::ST_OK)) |-> result_value == '0)
		else $error("nonzero value with error status");
endmodule

// ----- test/tb_modal_basis_project_reconstruct_unit.sv -----
`timescale 1ns / 1ps
module tb_modal_basis_project_reconstruct_unit;

	localparam int NMODES = 16;
	localparam int NNODES = 256;
	localparam int ROWLEN = 3 * NNODES;
	localparam int STALL_LIMIT = 20000;
	localparam int RAND_PER_PHASE = 170;

	typedef struct {
		mbpr_pkg::action_t act;
		logic [3:0] mode;
		logic [9:0] coord;
		logic [7:0] slot;
		logic [19:0] id;
		logic signed [15:0] coef;
		logic signed [23:0] wt;
		logic signed [23:0] x;
		logic signed [23:0] y;
		logic signed [23:0] z;
		bit known;
		mbpr_pkg::status_t st;
		logic signed [51:0] val;
	} beat_t;

	typedef struct {
		mbpr_pkg::status_t st;
		logic signed [51:0] val;
	} answer_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic cfg_index;
	logic [8:0] cfg_data;
	logic in_valid;
	logic in_stall;
	logic [2:0] action;
	logic [3:0] mode_index;
	logic [9:0] coord_index;
	logic [7:0] node_slot;
	logic [19:0] node_id;
	logic signed [15:0] coefficient;
	logic signed [23:0] weight;
	logic signed [23:0] x_coord;
	logic signed [23:0] y_coord;
	logic signed [23:0] z_coord;
	logic out_valid;
	logic out_stall;
	logic [1:0] status;
	logic signed [51:0] result_value;

	modal_basis_project_reconstruct_unit u_top (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .in_valid(in_valid), .in_stall(in_stall),
		.action(action), .mode_index(mode_index), .coord_index(coord_index),
		.node_slot(node_slot), .node_id(node_id), .coefficient(coefficient),
		.weight(weight), .x_coord(x_coord), .y_coord(y_coord), .z_coord(z_coord),
		.out_valid(out_valid), .out_stall(out_stall), .status(status),
		.result_value(result_value)
	);

	// model state
	logic signed [15:0] basis_m [NMODES*ROWLEN];
	bit basis_set [NMODES*ROWLEN];
	logic [19:0] ids_m [NNODES];
	bit id_set [NNODES];
	logic signed [23:0] wts_m [NMODES];
	bit wt_set [NMODES];
	longint sums_m [NMODES];
	int modes_raw;
	int nodes_raw;

	answer_t expected_q[$];
	beat_t dir_tab[$];
	int errors;
	int shown;
	int gap_pct;
	int stall_pct;
	int hold_cycles;
	int quiet;
	int sent;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic int active_modes();
		return modes_raw < 1 ? 1 : (modes_raw > NMODES ? NMODES : modes_raw);
	endfunction

	function automatic int active_nodes();
		return nodes_raw < 1 ? 1 : (nodes_raw > NNODES ? NNODES : nodes_raw);
	endfunction

	function automatic longint clip52(longint v);
		longint hi;
		hi = (longint'(1) <<< 51) - 1;
		if (v > hi) return hi;
		if (v < -hi - 1) return -hi - 1;
		return v;
	endfunction

	// last valid slot below the active count wins; -1 if none
	function automatic int find_slot(logic [19:0] id);
		int loc;
		loc = -1;
		for (int i = 0; i < active_nodes(); i++)
			if (id_set[i] && ids_m[i] == id) loc = i;
		return loc;
	endfunction

	function automatic answer_t apply_beat(beat_t b);
		answer_t r;
		int m;
		int n;
		int loc;
		longint acc;
		m = active_modes();
		n = active_nodes();
		r.st = mbpr_pkg::ST_OK;
		r.val = '0;
		case (b.act)
			mbpr_pkg::ACT_LOAD_COEF: begin
				if (b.mode < m && b.coord < 3 * n) begin
					basis_m[b.mode*ROWLEN + b.coord] = b.coef;
					basis_set[b.mode*ROWLEN + b.coord] = 1'b1;
				end else r.st = mbpr_pkg::ST_RANGE;
			end
			mbpr_pkg::ACT_LOAD_NODE: begin
				if (b.slot < n) begin
					ids_m[b.slot] = b.id;
					id_set[b.slot] = 1'b1;
				end else r.st = mbpr_pkg::ST_RANGE;
			end
			mbpr_pkg::ACT_SET_WEIGHT: begin
				if (b.mode < m) begin
					wts_m[b.mode] = b.wt;
					wt_set[b.mode] = 1'b1;
				end else r.st = mbpr_pkg::ST_RANGE;
			end
			mbpr_pkg::ACT_RECON: begin
				if (b.coord < 3 * n) begin
					acc = 0;
					for (int i = 0; i < m; i++)
						acc += longint'(basis_m[i*ROWLEN + b.coord]) * longint'(wts_m[i]);
					r.val = 52'(clip52(acc));
				end else r.st = mbpr_pkg::ST_RANGE;
			end
			mbpr_pkg::ACT_CLEAR: for (int i = 0; i < NMODES; i++) sums_m[i] = 0;
			mbpr_pkg::ACT_PROJECT: begin
				loc = find_slot(b.id);
				if (loc < 0) r.st = mbpr_pkg::ST_NOT_FOUND;
				else begin
					for (int i = 0; i < m; i++) begin
						acc = longint'(basis_m[i*ROWLEN + 3*loc]) * longint'(b.x)
							+ longint'(basis_m[i*ROWLEN + 3*loc + 1]) * longint'(b.y)
							+ longint'(basis_m[i*ROWLEN + 3*loc + 2]) * longint'(b.z);
						sums_m[i] = clip52(sums_m[i] + acc);
					end
				end
			end
			mbpr_pkg::ACT_READ: begin
				if (b.mode < m) r.val = 52'(sums_m[b.mode]);
				else r.st = mbpr_pkg::ST_RANGE;
			end
			default: r.st = mbpr_pkg::ST_RANGE;
		endcase
		return r;
	endfunction

	function automatic logic signed [15:0] rand_coef();
		case ($urandom_range(0, 9))
			0: return 16'sh8000;
			1: return 16'sh7fff;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic signed [23:0] rand_w24();
		case ($urandom_range(0, 9))
			0: return 24'sh800000;
			1: return 24'sh7fffff;
			default: return 24'($urandom);
		endcase
	endfunction

	function automatic beat_t blank_beat(mbpr_pkg::action_t a);
		beat_t b;
		b.act = a;
		b.mode = 4'($urandom);
		b.coord = 10'($urandom);
		b.slot = 8'($urandom);
		b.id = 20'($urandom);
		b.coef = rand_coef();
		b.wt = rand_w24();
		b.x = rand_w24();
		b.y = rand_w24();
		b.z = rand_w24();
		b.known = 1'b0;
		b.st = mbpr_pkg::ST_OK;
		b.val = '0;
		return b;
	endfunction

	// If b would read a coefficient or weight never written, return a load for it
	function automatic bit need_fill(beat_t b, output beat_t f);
		int m;
		int loc;
		m = active_modes();
		if (b.act == mbpr_pkg::ACT_RECON && b.coord < 3 * active_nodes()) begin
			for (int i = 0; i < m; i++) begin
				if (!wt_set[i]) begin
					f = blank_beat(mbpr_pkg::ACT_SET_WEIGHT);
					f.mode = 4'(i);
					return 1'b1;
				end
				if (!basis_set[i*ROWLEN + b.coord]) begin
					f = blank_beat(mbpr_pkg::ACT_LOAD_COEF);
					f.mode = 4'(i);
					f.coord = b.coord;
					return 1'b1;
				end
			end
		end else if (b.act == mbpr_pkg::ACT_PROJECT) begin
			loc = find_slot(b.id);
			if (loc >= 0)
				for (int i = 0; i < m; i++)
					for (int k = 0; k < 3; k++)
						if (!basis_set[i*ROWLEN + 3*loc + k]) begin
							f = blank_beat(mbpr_pkg::ACT_LOAD_COEF);
							f.mode = 4'(i);
							f.coord = 10'(3*loc + k);
							return 1'b1;
						end
		end
		return 1'b0;
	endfunction

	function automatic beat_t rand_beat();
		beat_t b;
		int p;
		int n;
		p = $urandom_range(0, 99);
		n = active_nodes();
		b = blank_beat(mbpr_pkg::ACT_READ);
		if (p < 14) b.act = mbpr_pkg::ACT_LOAD_COEF;
		else if (p < 24) b.act = mbpr_pkg::ACT_LOAD_NODE;
		else if (p < 30) b.act = mbpr_pkg::ACT_SET_WEIGHT;
		else if (p < 50) b.act = mbpr_pkg::ACT_RECON;
		else if (p < 53) b.act = mbpr_pkg::ACT_CLEAR;
		else if (p < 78) b.act = mbpr_pkg::ACT_PROJECT;
		else if (p < 97) b.act = mbpr_pkg::ACT_READ;
		else b.act = mbpr_pkg::ACT_BAD;
		// mostly in range; the rest keeps full-width values
		if ($urandom_range(0, 9) < 8) begin
			b.coord = 10'($urandom_range(0, 3*n - 1));
			b.slot = 8'($urandom_range(0, n - 1));
			b.mode = 4'($urandom_range(0, active_modes() - 1));
			// low slots and coordinates mostly, so the basis fills up quickly
			if ($urandom_range(0, 3) != 0) begin
				b.coord = 10'($urandom_range(0, (3*n < 24 ? 3*n : 24) - 1));
				b.slot = 8'($urandom_range(0, (n < 8 ? n : 8) - 1));
			end
		end
		// small id pool so lookups hit
		if ($urandom_range(0, 9) < 8) begin
			case ($urandom_range(0, 3))
				0: b.id = 20'hfffff;
				default: b.id = 20'($urandom_range(0, 11));
			endcase
		end
		return b;
	endfunction

	function automatic beat_t row(mbpr_pkg::action_t a, int mode, int coord, int slot,
			int id, int coef, int wt, int x, int y, int z, bit known,
			mbpr_pkg::status_t st);
		beat_t b;
		b = blank_beat(a);
		b.mode = 4'(mode);
		b.coord = 10'(coord);
		b.slot = 8'(slot);
		b.id = 20'(id);
		b.coef = 16'(coef);
		b.wt = 24'(wt);
		b.x = 24'(x);
		b.y = 24'(y);
		b.z = 24'(z);
		b.known = known;
		b.st = st;
		b.val = '0;
		return b;
	endfunction

	task automatic put_beat(beat_t b);
		answer_t r;
		while ($urandom_range(0, 99) < gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		action <= b.act;
		mode_index <= b.mode;
		coord_index <= b.coord;
		node_slot <= b.slot;
		node_id <= b.id;
		coefficient <= b.coef;
		weight <= b.wt;
		x_coord <= b.x;
		y_coord <= b.y;
		z_coord <= b.z;
		do @(posedge clk); while (!(in_valid && !in_stall));
		r = apply_beat(b);
		if (b.known) begin
			r.st = b.st;
			r.val = b.val;
		end
		expected_q.push_back(r);
		sent++;
	endtask

	task automatic send_checked(beat_t b);
		beat_t f;
		while (need_fill(b, f)) put_beat(f);
		put_beat(b);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_q.size() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, int val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= 9'(val);
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == 1'(mbpr_pkg::CFG_IDX_MODES)) modes_raw = val & 5'h1f;
		else nodes_raw = val & 9'h1ff;
	endtask

	// receiver
	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			out_stall <= 1'b1;
		end else out_stall <= ($urandom_range(0, 99) < stall_pct);
	end

	// result checking
	always @(posedge clk) begin
		answer_t e;
		if (out_valid && !out_stall) begin
			if (expected_q.size() == 0) begin
				errors++;
				if (shown < 10) begin
					shown++;
					$display("unexpected beat: status %0d value %0d", status, result_value);
				end
			end else begin
				e = expected_q.pop_front();
				if (status !== e.st || result_value !== e.val) begin
					errors++;
					if (shown < 10) begin
						shown++;
						$display("mismatch: expected status %0d value %0d, got %0d %0d",
							e.st, e.val, status, result_value);
					end
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet <= 0;
		else quiet <= quiet + 1;
		if (quiet >= STALL_LIMIT) begin
			$display("tb_modal_basis_project_reconstruct_unit: FAIL");
			$finish;
		end
	end

	initial begin
		int mcfg [6];
		int ncfg [6];
		int target;
		mcfg = '{0, 31, 16, 5, 1, 16};
		ncfg = '{0, 511, 3, 7, 256, 256};
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = 1'b0;
		cfg_data = '0;
		in_valid = 1'b0;
		action = '0;
		mode_index = '0;
		coord_index = '0;
		node_slot = '0;
		node_id = '0;
		coefficient = '0;
		weight = '0;
		x_coord = '0;
		y_coord = '0;
		z_coord = '0;
		out_stall = 1'b0;
		errors = 0;
		shown = 0;
		gap_pct = 0;
		stall_pct = 0;
		hold_cycles = 0;
		quiet = 0;
		sent = 0;
		modes_raw = 16;
		nodes_raw = 256;
		for (int i = 0; i < NNODES; i++) id_set[i] = 1'b0;
		for (int i = 0; i < NMODES; i++) begin
			wt_set[i] = 1'b0;
			sums_m[i] = 0;
		end
		for (int i = 0; i < NMODES*ROWLEN; i++) basis_set[i] = 1'b0;

		dir_tab.push_back(row(mbpr_pkg::ACT_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1,
			mbpr_pkg::ST_OK));
		dir_tab.push_back(row(mbpr_pkg::ACT_READ, 15, 0, 0, 0, 0, 0, 0, 0, 0, 1,
			mbpr_pkg::ST_OK));
		dir_tab.push_back(row(mbpr_pkg::ACT_PROJECT, 0, 0, 0, 0, 0, 0, 1, 1, 1, 1,
			mbpr_pkg::ST_NOT_FOUND));
		dir_tab.push_back(row(mbpr_pkg::ACT_BAD, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1,
			mbpr_pkg::ST_RANGE));
		dir_tab.push_back(row(mbpr_pkg::ACT_LOAD_COEF, 0, 768, 0, 0, 5, 0, 0, 0, 0, 1,
			mbpr_pkg::ST_RANGE));
		dir_tab.push_back(row(mbpr_pkg::ACT_LOAD_COEF, 15, 767, 0, 0, -32768, 0, 0, 0, 0, 1,
			mbpr_pkg::ST_OK));
		dir_tab.push_back(row(mbpr_pkg::ACT_LOAD_COEF, 0, 0, 0, 0, 32767, 0, 0, 0, 0, 1,
			mbpr_pkg::ST_OK));
		dir_tab.push_back(row(mbpr_pkg::ACT_LOAD_NODE, 0, 0, 255, 'hfffff, 0, 0, 0, 0, 0, 1,
			mbpr_pkg::ST_OK));
		dir_tab.push_back(row(mbpr_pkg::ACT_LOAD_NODE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1,
			mbpr_pkg::ST_OK));
		dir_tab.push_back(row(mbpr_pkg::ACT_LOAD_NODE, 0, 0, 3, 'hfffff, 0, 0, 0, 0, 0, 1,
			mbpr_pkg::ST_OK));
		dir_tab.push_back(row(mbpr_pkg::ACT_SET_WEIGHT, 15, 0, 0, 0, 0, -8388608, 0, 0, 0, 1,
			mbpr_pkg::ST_OK));
		dir_tab.push_back(row(mbpr_pkg::ACT_SET_WEIGHT, 0, 0, 0, 0, 0, 8388607, 0, 0, 0, 1,
			mbpr_pkg::ST_OK));
		dir_tab.push_back(row(mbpr_pkg::ACT_RECON, 0, 767, 0, 0, 0, 0, 0, 0, 0, 0,
			mbpr_pkg::ST_OK));
		dir_tab.push_back(row(mbpr_pkg::ACT_RECON, 0, 1023, 0, 0, 0, 0, 0, 0, 0, 1,
			mbpr_pkg::ST_RANGE));
		dir_tab.push_back(row(mbpr_pkg::ACT_PROJECT, 0, 0, 0, 'hfffff, 0, 0,
			8388607, -8388608, -1, 0, mbpr_pkg::ST_OK));
		dir_tab.push_back(row(mbpr_pkg::ACT_READ, 15, 0, 0, 0, 0, 0, 0, 0, 0, 0,
			mbpr_pkg::ST_OK));
		dir_tab.push_back(row(mbpr_pkg::ACT_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1,
			mbpr_pkg::ST_OK));
		dir_tab.push_back(row(mbpr_pkg::ACT_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1,
			mbpr_pkg::ST_OK));
		dir_tab.push_back(row(mbpr_pkg::ACT_PROJECT, 0, 0, 0, 0, 0, 0,
			-8388608, 8388607, -8388608, 0, mbpr_pkg::ST_OK));
		dir_tab.push_back(row(mbpr_pkg::ACT_READ, 7, 0, 0, 0, 0, 0, 0, 0, 0, 0,
			mbpr_pkg::ST_OK));
		dir_tab.push_back(row(mbpr_pkg::ACT_RECON, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0,
			mbpr_pkg::ST_OK));

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tab[i]) send_checked(dir_tab[i]);
		drain();

		for (int ph = 0; ph < 6; ph++) begin
			write_reg(1'(mbpr_pkg::CFG_IDX_MODES), mcfg[ph]);
			write_reg(1'(mbpr_pkg::CFG_IDX_NODES), ncfg[ph]);
			case (ph % 4)
				0: begin gap_pct = 0; stall_pct = 0; end
				1: begin gap_pct = 76; stall_pct = 0; end
				2: begin gap_pct = 0; stall_pct = 76; end
				default: begin gap_pct = 18; stall_pct = 18; end
			endcase
			// long receiver hold-off while beats keep coming
			if (ph == 4) hold_cycles <= 1500;
			// fill loads count toward the phase budget
			target = sent + RAND_PER_PHASE;
			while (sent < target) send_checked(rand_beat());
			drain();
		end

		repeat (200) @(posedge clk);
		if (errors == 0 && expected_q.size() == 0)
			$display("tb_modal_basis_project_reconstruct_unit: PASS");
		else
			$display("tb_modal_basis_project_reconstruct_unit: FAIL");
		$finish;
	end

endmodule

// ----- filelist.f -----
src/mbpr_pkg.sv
src/mbpr_lane.sv
src/mbpr_mac.sv
src/modal_basis_project_reconstruct_unit.sv
test/tb_modal_basis_project_reconstruct_unit.sv
